### sv/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// shared constants and types of the int8 vector distance accumulator
// ----------------------------------------------------------------------------
package vda_pkg;

    localparam int unsigned MAX_DIM  = 4096;
    localparam int unsigned TAKEN_W  = $clog2(MAX_DIM + 1);

    localparam int unsigned ELEM_W   = 8;
    localparam int unsigned MAIN_W   = 29;
    localparam int unsigned NORM_W   = 27;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned METRIC_W = 2;

    localparam logic [METRIC_W-1:0] METRIC_L2  = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_IP  = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_COS = 2'd2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last;
        logic [METRIC_W-1:0]      metric;
    } stage_item_t;

endpackage

### sv/vda_if.sv
// ----------------------------------------------------------------------------
// vda channel interfaces
// valid/ready channels for element pairs, results and the metric register
// ----------------------------------------------------------------------------
interface vda_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] elem_a;
    logic signed [7:0] elem_b;
    logic              last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface vda_out_if;
    logic               valid;
    logic               ready;
    logic signed [28:0] main_sum;
    logic [26:0]        a_sq_sum;
    logic [26:0]        b_sq_sum;
    logic [12:0]        element_count;
    logic               too_long;

    modport source (output valid, output main_sum, output a_sq_sum, output b_sq_sum,
                    output element_count, output too_long, input ready);
    modport sink   (input valid, input main_sum, input a_sq_sum, input b_sq_sum,
                    input element_count, input too_long, output ready);
endinterface

interface vda_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] metric;

    modport source (output valid, output metric, input ready);
    modport sink   (input valid, input metric, output ready);
endinterface

### sv/vda_in_stage.sv
// ----------------------------------------------------------------------------
// vda_in_stage
// input register for one element pair and the metric in force
// ----------------------------------------------------------------------------
module vda_in_stage import vda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    vda_in_if.sink              elems,
    input  logic [METRIC_W-1:0] metric,
    input  logic                acc_ready,
    output logic                stage_valid,
    output stage_item_t         stage_item
);

    logic        valid_reg;
    logic        valid_next;
    stage_item_t item_reg;
    logic        load;

    assign elems.ready = !valid_reg || acc_ready;
    assign load        = elems.valid && elems.ready;
    assign valid_next  = elems.ready ? elems.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.elem_a <= elems.elem_a;
            item_reg.elem_b <= elems.elem_b;
            item_reg.last   <= elems.last;
            item_reg.metric <= metric;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

### sv/vda_accum.sv
// ----------------------------------------------------------------------------
// vda_accum
// term arithmetic, running sums and the result register
// ----------------------------------------------------------------------------
module vda_accum import vda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stage_valid,
    input  stage_item_t stage_item,
    output logic        acc_ready,
    vda_out_if.source   result
);

    logic [MAIN_W-1:0]  main_reg;
    logic [MAIN_W-1:0]  main_next;
    logic [NORM_W-1:0]  norm_a_reg;
    logic [NORM_W-1:0]  norm_a_next;
    logic [NORM_W-1:0]  norm_b_reg;
    logic [NORM_W-1:0]  norm_b_next;
    logic [TAKEN_W-1:0] taken_reg;
    logic [TAKEN_W-1:0] taken_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic signed [8:0]  diff;
    logic signed [17:0] diff_sq;
    logic signed [15:0] prod;
    logic signed [15:0] sq_a;
    logic signed [15:0] sq_b;
    logic signed [17:0] term;
    logic               room;
    logic               fire;
    logic               emit;
    logic               is_cos;

    // per-pair terms
    assign diff    = $signed({stage_item.elem_a[7], stage_item.elem_a})
                   - $signed({stage_item.elem_b[7], stage_item.elem_b});
    assign diff_sq = diff * diff;
    assign prod    = stage_item.elem_a * stage_item.elem_b;
    assign sq_a    = stage_item.elem_a * stage_item.elem_a;
    assign sq_b    = stage_item.elem_b * stage_item.elem_b;

    always_comb
    begin
        unique case (stage_item.metric) inside
            METRIC_IP, METRIC_COS: term = {{2{prod[15]}}, prod};
            default:               term = diff_sq;
        endcase
    end

    assign acc_ready = !stage_item.last || !out_valid_reg || result.ready;
    assign fire      = stage_valid && acc_ready;
    assign emit      = fire && stage_item.last;
    assign room      = taken_reg < TAKEN_W'(MAX_DIM);
    assign is_cos    = stage_item.metric == METRIC_COS;

    always_comb
    begin
        main_next   = main_reg;
        norm_a_next = norm_a_reg;
        norm_b_next = norm_b_reg;
        taken_next  = taken_reg;
        ovf_next    = ovf_reg;
        if (fire)
        begin
            if (room)
            begin
                main_next   = main_reg + {{(MAIN_W-18){term[17]}}, term};
                norm_a_next = norm_a_reg + NORM_W'($unsigned(sq_a));
                norm_b_next = norm_b_reg + NORM_W'($unsigned(sq_b));
                taken_next  = taken_reg + TAKEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign out_valid_next = (out_valid_reg && !result.ready) || emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg      <= '0;
            norm_a_reg    <= '0;
            norm_b_reg    <= '0;
            taken_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                main_reg   <= '0;
                norm_a_reg <= '0;
                norm_b_reg <= '0;
                taken_reg  <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                main_reg   <= main_next;
                norm_a_reg <= norm_a_next;
                norm_b_reg <= norm_b_next;
                taken_reg  <= taken_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result.main_sum      <= $signed(main_next);
            result.a_sq_sum      <= is_cos ? norm_a_next : '0;
            result.b_sq_sum      <= is_cos ? norm_b_next : '0;
            result.element_count <= COUNT_W'(taken_next);
            result.too_long      <= ovf_next;
        end
    end

    assign result.valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= TAKEN_W'(MAX_DIM))
        else $error("pair count above maximum dimension");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> taken_reg == TAKEN_W'(MAX_DIM))
        else $error("overflow flagged before vector full");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> taken_reg == '0 && main_reg == '0 && !ovf_reg && result.valid)
        else $error("state not cleared or result missing after last item");

    a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !is_cos |=> result.a_sq_sum == '0 && result.b_sq_sum == '0)
        else $error("norm sums nonzero outside cosine mode");
`endif

endmodule

### sv/int8_vector_distance_accumulator_top.sv
// ----------------------------------------------------------------------------
// int8_vector_distance_accumulator_top
// exact int8 squared euclidean, inner product and cosine sums over a vector
// ----------------------------------------------------------------------------
// channel  role    payload
// elems    sink    elem_a, elem_b, last
// result   source  main_sum, a_sq_sum, b_sq_sum, element_count, too_long
// cfg      sink    metric
//
// one pair per cycle unless a stalled result holds back a last item; set by the input
// register and one multiply-add per sum; a result passes the input and result registers
// rst_n clears the sums, the count, the metric and both valid stages
// a stalled result blocks only a following last item; other pairs keep flowing
// ----------------------------------------------------------------------------
module int8_vector_distance_accumulator_top import vda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vda_in_if.sink    elems,
    vda_out_if.source result,
    vda_cfg_if.sink   cfg
);

    logic [METRIC_W-1:0] metric_reg;
    logic                acc_ready;
    logic                stage_valid;
    stage_item_t         stage_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_L2;
        end
        else if (cfg.valid)
        begin
            metric_reg <= cfg.metric;
        end
    end

    vda_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .elems       (elems),
        .metric      (metric_reg),
        .acc_ready   (acc_ready),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    vda_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .acc_ready   (acc_ready),
        .result      (result)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the int8 vector distance accumulator
// ----------------------------------------------------------------------------
// element pairs stream in over the elems channel while the metric register
// is switched between vectors and in the middle of some of them. each
// accepted pair updates a local copy of the running sums; every result is
// compared field by field with the oldest predicted one. covers the element
// extremes, all four metric codes, vectors of one pair, plus random vectors
// with random stalls on both sides and a stall-free closing stretch
// ----------------------------------------------------------------------------
module tb;
    import vda_pkg::*;

    localparam logic [METRIC_W-1:0] METRIC_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PAIRS = 930;
    localparam int QUIET_PAIRS = 150;

    typedef struct packed {
        logic [MAIN_W-1:0]  main_sum;
        logic [NORM_W-1:0]  a_sq_sum;
        logic [NORM_W-1:0]  b_sq_sum;
        logic [COUNT_W-1:0] element_count;
        logic               too_long;
    } vector_sums_t;

    class distance_scoreboard;
        logic [METRIC_W-1:0] metric;
        logic [29:0]         main_acc;
        logic [NORM_W-1:0]   norm_a_acc;
        logic [NORM_W-1:0]   norm_b_acc;
        int unsigned         taken;
        bit                  overflow;
        vector_sums_t        pending[$];
        int                  errors;
        int                  checked;

        function new();
            metric = METRIC_L2;
            errors = 0;
            checked = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            main_acc = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
            taken = 0;
            overflow = 1'b0;
        endfunction

        function void set_metric(logic [METRIC_W-1:0] m);
            metric = m;
        endfunction

        function void note_pair(logic signed [7:0] a, logic signed [7:0] b, logic last);
            int ai;
            int bi;
            int term;
            int sq_a;
            int sq_b;
            vector_sums_t sums;
            ai = a;
            bi = b;
            if (taken < MAX_DIM)
            begin
                if (metric == METRIC_IP || metric == METRIC_COS)
                    term = ai * bi;
                else
                    term = (ai - bi) * (ai - bi);
                sq_a = ai * ai;
                sq_b = bi * bi;
                main_acc = main_acc + term[29:0];
                norm_a_acc = norm_a_acc + sq_a[NORM_W-1:0];
                norm_b_acc = norm_b_acc + sq_b[NORM_W-1:0];
                taken++;
            end
            else
                overflow = 1'b1;
            if (last)
            begin
                sums.main_sum = main_acc[MAIN_W-1:0];
                sums.a_sq_sum = (metric == METRIC_COS) ? norm_a_acc : '0;
                sums.b_sq_sum = (metric == METRIC_COS) ? norm_b_acc : '0;
                sums.element_count = taken[COUNT_W-1:0];
                sums.too_long = overflow;
                pending.push_back(sums);
                clear_sums();
            end
        endfunction

        function void check(vector_sums_t got);
            vector_sums_t want;
            if (pending.size() == 0)
            begin
                $error("result with no vector pending: main_sum %0d count %0d",
                       $signed(got.main_sum), got.element_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.main_sum !== want.main_sum)
            begin
                $error("main_sum: expected %0d, actual %0d",
                       $signed(want.main_sum), $signed(got.main_sum));
                errors++;
            end
            if (got.a_sq_sum !== want.a_sq_sum)
            begin
                $error("a_sq_sum: expected %0d, actual %0d", want.a_sq_sum, got.a_sq_sum);
                errors++;
            end
            if (got.b_sq_sum !== want.b_sq_sum)
            begin
                $error("b_sq_sum: expected %0d, actual %0d", want.b_sq_sum, got.b_sq_sum);
                errors++;
            end
            if (got.element_count !== want.element_count)
            begin
                $error("element_count: expected %0d, actual %0d",
                       want.element_count, got.element_count);
                errors++;
            end
            if (got.too_long !== want.too_long)
            begin
                $error("too_long: expected %0d, actual %0d", want.too_long, got.too_long);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vda_in_if  elems();
    vda_out_if result();
    vda_cfg_if cfg();

    distance_scoreboard sb = new();
    vector_sums_t seen_sums;
    bit quiet = 1'b0;
    int pairs_sent = 0;
    int vectors_sent = 0;
    int metric_writes = 0;
    int idle_cycles = 0;

    int8_vector_distance_accumulator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elems  (elems),
        .result (result),
        .cfg    (cfg)
    );

    always #10 clk = ~clk;

    // result side: random stall bursts until the closing stretch
    initial
    begin
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            seen_sums.main_sum = result.main_sum;
            seen_sums.a_sq_sum = result.a_sq_sum;
            seen_sums.b_sq_sum = result.b_sq_sum;
            seen_sums.element_count = result.element_count;
            seen_sums.too_long = result.too_long;
            sb.check(seen_sums);
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elems.valid && elems.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [7:0] random_elem();
        case ($urandom_range(0, 9))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            3: return 8'($urandom_range(0, 6) - 3);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pair(logic signed [7:0] a, logic signed [7:0] b, logic last);
        elems.valid <= 1'b1;
        elems.elem_a <= a;
        elems.elem_b <= b;
        elems.last <= last;
        @(posedge clk);
        while (!elems.ready)
            @(posedge clk);
        sb.note_pair(a, b, last);
        pairs_sent++;
        if (last)
            vectors_sent++;
    endtask

    task automatic input_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            elems.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // hold the input until every pending result is back and the pipe is empty
    task automatic drain();
        elems.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_metric(logic [METRIC_W-1:0] m);
        cfg.valid <= 1'b1;
        cfg.metric <= m;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.set_metric(m);
        metric_writes++;
        cfg.valid <= 1'b0;
    endtask

    task automatic send_random_vector(int len, bit switch_metric);
        int switch_at;
        switch_at = (switch_metric && len > 1) ? $urandom_range(1, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            if (i == switch_at)
            begin
                drain();
                write_metric(METRIC_W'($urandom_range(0, 3)));
            end
            input_gap();
            send_pair(random_elem(), random_elem(), i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        rst_n <= 1'b0;
        elems.valid <= 1'b0;
        elems.elem_a <= '0;
        elems.elem_b <= '0;
        elems.last <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.metric <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset metric is squared euclidean, largest single difference
        send_pair(8'sd127, -8'sd128, 1'b1);
        drain();
        write_metric(METRIC_IP);
        send_pair(-8'sd128, -8'sd128, 1'b0);
        send_pair(8'sd127, -8'sd128, 1'b1);
        drain();
        write_metric(METRIC_COS);
        send_pair(-8'sd128, 8'sd127, 1'b0);
        send_pair(8'sd0, 8'sd0, 1'b0);
        send_pair(8'sd1, -8'sd1, 1'b1);
        drain();
        write_metric(METRIC_SPARE);
        send_pair(8'sd5, -8'sd7, 1'b1);
        drain();

        // metric switched mid-vector, norms kept running throughout
        write_metric(METRIC_L2);
        send_pair(8'sd10, 8'sd3, 1'b0);
        drain();
        write_metric(METRIC_COS);
        send_pair(8'sd2, 8'sd4, 1'b1);
        drain();
        write_metric(METRIC_IP);
        send_pair(8'sd3, 8'sd4, 1'b0);
        drain();
        write_metric(METRIC_L2);
        send_pair(8'sd1, 8'sd1, 1'b1);
        drain();

        len = pairs_sent;
        while (pairs_sent - len < RANDOM_PAIRS)
        begin
            if (pairs_sent - len >= RANDOM_PAIRS - QUIET_PAIRS)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                drain();
                write_metric(METRIC_W'($urandom_range(0, 3)));
            end
            case ($urandom_range(0, 19))
                0:       send_random_vector($urandom_range(41, 100), 1'b0);
                1, 2, 3: send_random_vector($urandom_range(9, 40), !quiet);
                default: send_random_vector($urandom_range(1, 8), 1'b0);
            endcase
        end

        elems.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("%0d element pairs in %0d vectors, %0d results checked, %0d metric writes",
                 pairs_sent, vectors_sent, sb.checked, metric_writes);
        $display("all four metric codes, mid-vector switches, vectors of 1 to 100 pairs");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### int8_vector_distance_accumulator_top.f
sv/vda_pkg.sv
sv/vda_if.sv
sv/vda_in_stage.sv
sv/vda_accum.sv
sv/int8_vector_distance_accumulator_top.sv
sim/tb.sv
